>>> hw/rtl/pals_pkg.sv
// Package for the polyline arc length sampler.
// Holds the request and response word types, command and status codes and constants.
// No dependencies.
`timescale 1ns / 1ps

package pals_pkg;

  localparam int MAX_POINTS_DEF = 64;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FEW  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_SAT  = 2'd3;

  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

  localparam logic [5:0] SQRT_LAST = 6'd31;
  localparam logic [5:0] DIV_LAST  = 6'd32;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [31:0]        query_distance;
  } pals_req_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic [5:0]         segment_index;
    logic [31:0]        total_length;
    logic [1:0]         status;
  } pals_rsp_t;

endpackage

>>> hw/rtl/polyline_arc_length_sampler.sv
// Polyline arc length sampler: point store, running length and query sequencer.
// Depends on pals_pkg for word types, codes and constants.
//
//   channel | signals               | handshake
//   --------+-----------------------+-----------------------------------------
//   request | start, busy, req      | word taken when start is high, busy low
//   result  | done, rsp             | word valid for the single cycle of done
//
// Clear, an append of the first point or to a full store, unknown commands and
// queries on fewer than two points answer in the cycle after the word is taken.
// An append that adds a segment waits on the 32-step square root loop. A query's
// time grows with the knots scanned, set by the knot scan (one memory read per
// knot), the square root and six 33-step divisions on one restoring divider.
// Reset clears the point count and total; the store needs no clearing pass.
// busy stays high while a word is in work; results cannot be stalled.
`timescale 1ns / 1ps

module polyline_arc_length_sampler import pals_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  pals_req_t req,
  output logic      busy,
  output logic      done,
  output pals_rsp_t rsp
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_DIFF = 5'd1;
  localparam logic [4:0] S_MUL  = 5'd2;
  localparam logic [4:0] S_ACC  = 5'd3;
  localparam logic [4:0] S_SQRT = 5'd4;
  localparam logic [4:0] S_AFIN = 5'd5;
  localparam logic [4:0] S_QRD  = 5'd6;
  localparam logic [4:0] S_QCMP = 5'd7;
  localparam logic [4:0] S_QLD  = 5'd8;
  localparam logic [4:0] S_QLA  = 5'd9;
  localparam logic [4:0] S_QLB  = 5'd10;
  localparam logic [4:0] S_QZ0  = 5'd11;
  localparam logic [4:0] S_QZ1  = 5'd12;
  localparam logic [4:0] S_PMUL = 5'd13;
  localparam logic [4:0] S_DSET = 5'd14;
  localparam logic [4:0] S_DIV  = 5'd15;
  localparam logic [4:0] S_DFIN = 5'd16;

  logic [4:0]         state;
  logic               is_qry;
  logic [CW-1:0]      cnt;
  logic [31:0]        total;
  logic [31:0]        d_q;
  logic [31:0]        k0;
  logic [31:0]        k1;
  logic [31:0]        kprev;
  logic [31:0]        off;
  logic [31:0]        kd;
  logic signed [31:0] prev_pt [3];
  logic signed [31:0] a_pt [3];
  logic signed [31:0] b_pt [3];
  logic [AW-1:0]      j;
  logic [AW-1:0]      found;
  logic               hit_any;
  logic [32:0]        dd [3];
  logic [32:0]        mg [3];
  logic [32:0]        sm [3];
  logic [1:0]         k;
  logic [65:0]        acc;
  logic               ovf;
  logic [65:0]        mul_p;
  logic [63:0]        sq_v;
  logic [63:0]        sq_r;
  logic [63:0]        sq_b;
  logic [5:0]         it;
  logic [2:0]         ph;
  logic [31:0]        div_rem;
  logic [31:0]        div_dvs;
  logic [32:0]        div_sh;
  logic [32:0]        div_q;

  logic [31:0] mem_x [MAX_POINTS];
  logic [31:0] mem_y [MAX_POINTS];
  logic [31:0] mem_z [MAX_POINTS];
  logic [31:0] mem_k [MAX_POINTS];
  logic [31:0] rd_x;
  logic [31:0] rd_y;
  logic [31:0] rd_z;
  logic [31:0] rd_k;

  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_x;
  logic [31:0]   wr_y;
  logic [31:0]   wr_z;
  logic [31:0]   wr_k;
  logic [32:0]   mul_a;
  logic [32:0]   mul_b;
  logic [65:0]   acc_sum;
  logic [63:0]   sq_t;
  logic [32:0]   div_t;
  logic          div_ge;
  logic [63:0]   dvd;
  logic [31:0]   len;
  logic [32:0]   sum33;
  logic [31:0]   newk;
  logic          sat;
  logic [32:0]   dd_n [3];
  logic [32:0]   mg_n [3];
  logic          halve;
  logic [1:0]    ax_i;
  logic [CW-1:0] cnt_m1;
  logic [33:0]   pos_n;
  logic [15:0]   qd;
  logic [15:0]   dir_n;

  function automatic pals_rsp_t rsp_word(logic [5:0] seg, logic [31:0] tl, logic [1:0] st);
    pals_rsp_t w;
    w               = '0;
    w.segment_index = seg;
    w.total_length  = tl;
    w.status        = st;
    return w;
  endfunction

  assign busy   = (state != S_IDLE);
  assign cnt_m1 = cnt - CW'(1);
  assign ax_i   = (ph < 3'd3) ? ph[1:0] : ph[1:0] - 2'd3;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dd_n[i] = {b_pt[i][31], b_pt[i]} - {a_pt[i][31], a_pt[i]};
      mg_n[i] = dd_n[i][32] ? (33'd0 - dd_n[i]) : dd_n[i];
    end
    halve = is_qry && ((|mg_n[0][32:31]) || (|mg_n[1][32:31]) || (|mg_n[2][32:31]));
  end

  always_comb begin
    mul_a = sm[k];
    mul_b = sm[k];
    if (state == S_PMUL) begin
      mul_a = mg[ax_i];
      mul_b = {1'b0, off};
    end
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  assign acc_sum = acc + mul_p;
  assign sq_t    = sq_r + sq_b;
  assign div_t   = {div_rem, div_sh[32]};
  assign div_ge  = (div_t >= {1'b0, div_dvs});
  assign dvd     = (ph < 3'd3) ? mul_p[63:0]
                 : (({31'd0, sm[ax_i]} << 14) + {1'b0, sq_r[63:1]});
  assign len     = ovf ? SAT32 : sq_r[31:0];
  assign sum33   = {1'b0, total} + {1'b0, len};
  assign sat     = ((len == SAT32) && (total != 32'd0)) || sum33[32];
  assign newk    = sum33[32] ? SAT32 : sum33[31:0];
  assign pos_n   = dd[ax_i][32] ? ({{2{a_pt[ax_i][31]}}, a_pt[ax_i]} - {1'b0, div_q})
                                : ({{2{a_pt[ax_i][31]}}, a_pt[ax_i]} + {1'b0, div_q});
  assign qd      = (div_dvs == 32'd0) ? 16'd0 : div_q[15:0];
  assign dir_n   = dd[ax_i][32] ? (16'd0 - qd) : qd;

  always_comb begin
    case (state)
      S_QRD:   rd_addr = j;
      S_QLD:   rd_addr = found;
      S_QLA:   rd_addr = found + AW'(1);
      default: rd_addr = '0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_x    = req.point_x;
    wr_y    = req.point_y;
    wr_z    = req.point_z;
    wr_k    = 32'd0;
    if (state == S_AFIN) begin
      wr_en   = 1'b1;
      wr_addr = cnt[AW-1:0];
      wr_x    = b_pt[0];
      wr_y    = b_pt[1];
      wr_z    = b_pt[2];
      wr_k    = newk;
    end else if (state == S_IDLE && start && req.cmd == CMD_APPEND &&
                 cnt == CW'(0)) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[wr_addr] <= wr_x;
      mem_y[wr_addr] <= wr_y;
      mem_z[wr_addr] <= wr_z;
      mem_k[wr_addr] <= wr_k;
    end
    rd_x <= mem_x[rd_addr];
    rd_y <= mem_y[rd_addr];
    rd_z <= mem_z[rd_addr];
    rd_k <= mem_k[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      total <= 32'd0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            case (req.cmd)
              CMD_CLEAR: begin
                cnt   <= '0;
                total <= 32'd0;
                rsp   <= '0;
                done  <= 1'b1;
              end
              CMD_APPEND: begin
                if (cnt >= CW'(MAX_POINTS)) begin
                  rsp  <= rsp_word(6'd0, total, ST_FULL);
                  done <= 1'b1;
                end else if (cnt == CW'(0)) begin
                  prev_pt[0] <= req.point_x;
                  prev_pt[1] <= req.point_y;
                  prev_pt[2] <= req.point_z;
                  cnt        <= CW'(1);
                  total      <= 32'd0;
                  rsp        <= '0;
                  done       <= 1'b1;
                end else begin
                  a_pt   <= prev_pt;
                  b_pt[0] <= req.point_x;
                  b_pt[1] <= req.point_y;
                  b_pt[2] <= req.point_z;
                  is_qry <= 1'b0;
                  state  <= S_DIFF;
                end
              end
              CMD_QUERY: begin
                if (cnt < CW'(2)) begin
                  rsp  <= rsp_word(6'd0, total, ST_FEW);
                  done <= 1'b1;
                end else begin
                  d_q     <= (req.query_distance > total) ? total : req.query_distance;
                  kprev   <= 32'd0;
                  j       <= AW'(1);
                  hit_any <= 1'b0;
                  is_qry  <= 1'b1;
                  state   <= S_QRD;
                end
              end
              default: begin
                rsp  <= rsp_word(6'd0, total, ST_OK);
                done <= 1'b1;
              end
            endcase
          end
        end
        S_DIFF: begin
          for (int i = 0; i < 3; i++) begin
            dd[i] <= dd_n[i];
            mg[i] <= mg_n[i];
            sm[i] <= halve ? (mg_n[i] >> 1) : mg_n[i];
          end
          acc   <= '0;
          k     <= 2'd0;
          state <= S_MUL;
        end
        S_MUL: begin
          state <= S_ACC;
        end
        S_ACC: begin
          acc <= acc_sum;
          if (k == 2'd2) begin
            sq_v  <= acc_sum[63:0];
            sq_r  <= 64'd0;
            sq_b  <= 64'd1 << 62;
            ovf   <= (acc_sum[65:64] != 2'd0);
            it    <= 6'd0;
            state <= S_SQRT;
          end else begin
            k     <= k + 2'd1;
            state <= S_MUL;
          end
        end
        S_SQRT: begin
          if (sq_v >= sq_t) begin
            sq_v <= sq_v - sq_t;
            sq_r <= (sq_r >> 1) + sq_b;
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_b <= sq_b >> 2;
          it   <= it + 6'd1;
          if (it == SQRT_LAST) begin
            ph    <= 3'd0;
            state <= is_qry ? S_PMUL : S_AFIN;
          end
        end
        S_AFIN: begin
          total   <= newk;
          prev_pt <= b_pt;
          cnt     <= cnt + CW'(1);
          rsp     <= rsp_word(6'd0, newk, sat ? ST_SAT : ST_OK);
          done    <= 1'b1;
          state   <= S_IDLE;
        end
        S_QRD: begin
          state <= S_QCMP;
        end
        S_QCMP: begin
          if (kprev <= d_q && d_q < rd_k) begin
            found <= j - AW'(1);
            k0    <= kprev;
            k1    <= rd_k;
            state <= S_QLD;
          end else begin
            if (rd_k > kprev) begin
              found   <= j - AW'(1);
              k0      <= kprev;
              k1      <= rd_k;
              hit_any <= 1'b1;
            end
            kprev <= rd_k;
            if (j == cnt_m1[AW-1:0]) begin
              state <= (hit_any || rd_k > kprev) ? S_QLD : S_QZ0;
            end else begin
              j     <= j + AW'(1);
              state <= S_QRD;
            end
          end
        end
        S_QLD: begin
          state <= S_QLA;
        end
        S_QLA: begin
          a_pt[0] <= rd_x;
          a_pt[1] <= rd_y;
          a_pt[2] <= rd_z;
          state   <= S_QLB;
        end
        S_QLB: begin
          b_pt[0] <= rd_x;
          b_pt[1] <= rd_y;
          b_pt[2] <= rd_z;
          off     <= d_q - k0;
          kd      <= k1 - k0;
          rsp     <= rsp_word(6'(found), total, ST_OK);
          state   <= S_DIFF;
        end
        S_QZ0: begin
          state <= S_QZ1;
        end
        S_QZ1: begin
          rsp   <= {rd_x, rd_y, rd_z, 48'd0, 6'd0, total, ST_OK};
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_PMUL: begin
          state <= S_DSET;
        end
        S_DSET: begin
          div_rem <= {1'b0, dvd[63:33]};
          div_sh  <= dvd[32:0];
          div_dvs <= (ph < 3'd3) ? kd : sq_r[31:0];
          div_q   <= 33'd0;
          it      <= 6'd0;
          state   <= S_DIV;
        end
        S_DIV: begin
          div_rem <= div_ge ? 32'(div_t - {1'b0, div_dvs}) : div_t[31:0];
          div_sh  <= div_sh << 1;
          div_q   <= {div_q[31:0], div_ge};
          it      <= it + 6'd1;
          if (it == DIV_LAST) begin
            state <= S_DFIN;
          end
        end
        S_DFIN: begin
          if (ph < 3'd3) begin
            case (ax_i)
              2'd0:    rsp.pos_x <= pos_n[31:0];
              2'd1:    rsp.pos_y <= pos_n[31:0];
              default: rsp.pos_z <= pos_n[31:0];
            endcase
          end else begin
            case (ax_i)
              2'd0:    rsp.dir_x <= dir_n;
              2'd1:    rsp.dir_y <= dir_n;
              default: rsp.dir_z <= dir_n;
            endcase
          end
          ph <= ph + 3'd1;
          if (ph == 3'd5) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else if (ph < 3'd2) begin
            state <= S_PMUL;
          end else begin
            state <= S_DSET;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A result word only follows a taken request or the end of a work sequence.
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start) || $past(busy)))
    else $error("result word without a request");

  a_cnt_max: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(MAX_POINTS))
    else $error("point count beyond store depth");

  a_few_pts: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == ST_FEW) |-> (cnt < CW'(2)))
    else $error("short polyline status with enough points");

  a_clear_total: assert property (@(posedge clk) disable iff (rst)
    (cnt == CW'(0)) |-> (total == 32'd0))
    else $error("nonzero total on an empty polyline");

endmodule

>>> tb/tb_top.sv
// Testbench for polyline_arc_length_sampler: builds polylines, runs arc length queries
// and checks every result word against a predictor kept in this file.
// Depends on pals_pkg and the polyline_arc_length_sampler RTL.
`timescale 1ns / 1ps

module tb_top;
  import pals_pkg::*;

  localparam logic [1:0] CMD_UNDEF = 2'd3;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  pals_req_t req = '0;
  logic      busy;
  logic      done;
  pals_rsp_t rsp;

  polyline_arc_length_sampler i_dut (
    .clk(clk), .rst(rst), .start(start), .req(req),
    .busy(busy), .done(done), .rsp(rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  longint    pt_x [MAX_POINTS_DEF];
  longint    pt_y [MAX_POINTS_DEF];
  longint    pt_z [MAX_POINTS_DEF];
  bit [31:0] knot [MAX_POINTS_DEF];
  int        npts = 0;
  pals_rsp_t expected_words [$];
  int        errors = 0;
  int        idle_pct = 0;
  int        n_words = 0;
  int        n_queries = 0;
  int        n_sat = 0;
  longint    cycles = 0;

  function automatic bit [63:0] isqrt(bit [63:0] v);
    bit [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic bit [63:0] magn(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic bit [31:0] segment_length(longint dx, longint dy, longint dz);
    bit [65:0] s;
    bit [63:0] r;
    s = 66'(magn(dx) * magn(dx)) + 66'(magn(dy) * magn(dy)) + 66'(magn(dz) * magn(dz));
    if (s[65:64] != 0) return SAT32;
    r = isqrt(s[63:0]);
    return (r > 64'(SAT32)) ? SAT32 : r[31:0];
  endfunction

  function automatic pals_rsp_t predict_word(pals_req_t r);
    pals_rsp_t w;
    longint    d [3];
    longint    p0 [3];
    bit [63:0] m [3];
    bit [63:0] s, l, q, off, kd;
    bit [32:0] sum;
    bit [31:0] len, qdist, tot;
    int        n, found;
    bit        hit;
    w = '0;
    if (r.cmd == CMD_CLEAR) begin
      npts = 0;
    end else if (r.cmd == CMD_APPEND) begin
      if (npts >= MAX_POINTS_DEF) begin
        w.status = ST_FULL;
      end else begin
        n = npts;
        pt_x[n] = r.point_x;
        pt_y[n] = r.point_y;
        pt_z[n] = r.point_z;
        if (n == 0) begin
          knot[0] = 32'd0;
        end else begin
          len = segment_length(pt_x[n] - pt_x[n-1], pt_y[n] - pt_y[n-1], pt_z[n] - pt_z[n-1]);
          sum = 33'(knot[n-1]) + 33'(len);
          if ((len == SAT32 && knot[n-1] != 0) || sum > 33'(SAT32)) begin
            w.status = ST_SAT;
            n_sat++;
          end
          knot[n] = (sum > 33'(SAT32)) ? SAT32 : sum[31:0];
        end
        npts = n + 1;
      end
    end else if (r.cmd == CMD_QUERY) begin
      n_queries++;
      if (npts < 2) begin
        w.status = ST_FEW;
      end else begin
        tot = knot[npts-1];
        qdist = (r.query_distance > tot) ? tot : r.query_distance;
        hit = 0;
        found = 0;
        for (int i = 0; i + 1 < npts; i++)
          if (!hit && qdist >= knot[i] && qdist < knot[i+1]) begin
            found = i;
            hit = 1;
          end
        if (!hit)
          for (int i = 0; i + 1 < npts; i++)
            if (knot[i+1] > knot[i]) begin
              found = i;
              hit = 1;
            end
        if (!hit) begin
          w.pos_x = 32'(pt_x[0]);
          w.pos_y = 32'(pt_y[0]);
          w.pos_z = 32'(pt_z[0]);
        end else begin
          p0[0] = pt_x[found]; p0[1] = pt_y[found]; p0[2] = pt_z[found];
          d[0] = pt_x[found+1] - p0[0];
          d[1] = pt_y[found+1] - p0[1];
          d[2] = pt_z[found+1] - p0[2];
          off = qdist - knot[found];
          kd = knot[found+1] - knot[found];
          for (int k = 0; k < 3; k++) begin
            q = magn(d[k]) * off / kd;
            p0[k] = (d[k] < 0) ? p0[k] - longint'(q) : p0[k] + longint'(q);
            m[k] = magn(d[k]);
          end
          w.pos_x = 32'(p0[0]);
          w.pos_y = 32'(p0[1]);
          w.pos_z = 32'(p0[2]);
          if (m[0] >= 64'h8000_0000 || m[1] >= 64'h8000_0000 || m[2] >= 64'h8000_0000)
            for (int k = 0; k < 3; k++) m[k] = m[k] >> 1;
          s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
          l = isqrt(s);
          for (int k = 0; k < 3; k++) begin
            q = (l == 0) ? 0 : (m[k] * 16384 + l / 2) / l;
            p0[k] = (d[k] < 0) ? -longint'(q) : longint'(q);
          end
          w.dir_x = 16'(p0[0]);
          w.dir_y = 16'(p0[1]);
          w.dir_z = 16'(p0[2]);
          w.segment_index = 6'(found);
        end
      end
    end
    w.total_length = (npts == 0) ? 32'd0 : knot[npts-1];
    return w;
  endfunction

  function automatic bit [31:0] current_total();
    return (npts == 0) ? 32'd0 : knot[npts-1];
  endfunction

  task automatic check_field(string name, longint e, longint a);
    if (e != a) begin
      $error("%s mismatch: expected %0h, got %0h", name, e, a);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    pals_rsp_t e;
    if (!rst && done) begin
      n_words++;
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        e = expected_words.pop_front();
        check_field("pos_x", e.pos_x, rsp.pos_x);
        check_field("pos_y", e.pos_y, rsp.pos_y);
        check_field("pos_z", e.pos_z, rsp.pos_z);
        check_field("dir_x", e.dir_x, rsp.dir_x);
        check_field("dir_y", e.dir_y, rsp.dir_y);
        check_field("dir_z", e.dir_z, rsp.dir_z);
        check_field("segment_index", e.segment_index, rsp.segment_index);
        check_field("total_length", e.total_length, rsp.total_length);
        check_field("status", e.status, rsp.status);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 64'd3_000_000) begin
      $display("[polyline_arc_length_sampler] ERROR");
      $finish;
    end
  end

  task automatic send_word(logic [1:0] cmd, logic [31:0] x, logic [31:0] y,
                           logic [31:0] z, logic [31:0] qdist);
    pals_req_t w;
    int gap;
    w.cmd = cmd;
    w.point_x = x;
    w.point_y = y;
    w.point_z = z;
    w.query_distance = qdist;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(5, 1) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req <= w;
    do @(posedge clk); while (busy);
    expected_words.push_back(predict_word(w));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic append_pt(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    send_word(CMD_APPEND, x, y, z, $urandom);
  endtask

  task automatic query(logic [31:0] qdist);
    send_word(CMD_QUERY, $urandom, $urandom, $urandom, qdist);
  endtask

  task automatic test_directed();
    send_word(CMD_CLEAR, 0, 0, 0, 0);
    query(0);
    append_pt(32'h0001_0000, 0, 0);
    query(32'hFFFF_FFFF);
    append_pt(32'h0001_0000, 0, 0);
    query(32'h0000_8000);
    append_pt(32'h0004_0000, 32'h0004_0000, 32'hFFFE_0000);
    query(0);
    query(current_total());
    query(32'hFFFF_FFFF);
    query(knot[2]);
    send_word(CMD_UNDEF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(CMD_CLEAR, 0, 0, 0, 0);
    append_pt(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    append_pt(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    query(32'h7FFF_FFFF);
    append_pt(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    append_pt(0, 0, 0);
    query(32'hFFFF_FFFF);
    query(32'h1234_5678);
    send_word(CMD_CLEAR, 0, 0, 0, 0);
    append_pt(32'h0003_0000, 32'hFFFF_0000, 32'h0000_0001);
    append_pt(32'h0003_0000, 32'hFFFF_0000, 32'h0000_0001);
    query(0);
    query(5);
  endtask

  task automatic test_full_store();
    send_word(CMD_CLEAR, 0, 0, 0, 0);
    for (int i = 0; i < MAX_POINTS_DEF + 2; i++)
      append_pt($urandom_range(2000) << 8, $urandom_range(2000) << 8, i << 12);
    query(current_total());
    query($urandom_range(current_total()));
    drain();
  endtask

  task automatic test_random(int items);
    int sent, npt, mode, nq;
    logic [31:0] bx, by, bz;
    sent = 0;
    while (sent < items) begin
      mode = $urandom_range(9);
      if (mode == 0) begin
        send_word(2'($urandom_range(3)), $urandom, $urandom, $urandom, $urandom);
        sent++;
        continue;
      end
      send_word(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
      npt = ($urandom_range(19) == 0) ? $urandom_range(MAX_POINTS_DEF + 3, 20)
                                       : $urandom_range(8, 1);
      bx = $urandom; by = $urandom; bz = $urandom;
      for (int i = 0; i < npt; i++) begin
        if (mode == 1) begin
          bx = $urandom; by = $urandom; bz = $urandom;
        end else if ($urandom_range(7) != 0) begin
          bx = bx + $signed(32'($urandom_range(32'h00FF_FFFF))) - 32'h0080_0000;
          by = by + $signed(32'($urandom_range(32'h00FF_FFFF))) - 32'h0080_0000;
          bz = bz + $signed(32'($urandom_range(32'h00FF_FFFF))) - 32'h0080_0000;
        end
        append_pt(bx, by, bz);
      end
      nq = $urandom_range(6, 1);
      for (int i = nq; i > 0; i--) begin
        case ($urandom_range(4))
          0: query($urandom);
          1: query(current_total());
          2: query(knot[$urandom_range(npts > 0 ? npts - 1 : 0)]);
          default: query($urandom_range(current_total()));
        endcase
      end
      sent += npt + 1 + nq;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    idle_pct = 38;
    test_directed();
    drain();
    test_full_store();
    test_random(530);
    drain();
    idle_pct = 74;
    test_random(530);
    idle_pct = 0;
    test_random(530);
    drain();
    repeat (40) @(posedge clk);
    $display("Covered clear, append, query and undefined words, full store, saturation,");
    $display("  zero-length segments: %0d results, %0d queries, %0d saturated appends.",
             n_words, n_queries, n_sat);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("[polyline_arc_length_sampler] OK");
    end else begin
      $display("[polyline_arc_length_sampler] ERROR");
    end
    $finish;
  end

endmodule
